// ===== hw/rtl/deadline_timer_queue_defines.svh =====
// assertion macros for the timer queue checker
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// consequent in the same cycle
`define DTQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue assertion failed");

// consequent in the next cycle
`define DTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue assertion failed");

`endif

// ===== hw/rtl/dtq_pkg.sv =====
package dtq_pkg;

    localparam int DEADLINE_W       = 48;
    localparam int ID_W             = 34;
    localparam int DEFAULT_CAPACITY = 16;

    localparam logic [ID_W-1:0] ID_LIMIT = 34'd10000000000;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_CANCEL = 2'd1,
        FUNC_TICK   = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        STATUS_STARTED   = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_CANCELLED = 3'd2,
        STATUS_NOT_FOUND = 3'd3,
        STATUS_EXPIRED   = 3'd4,
        STATUS_NONE      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_POP    = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_TICK = 2'd2
    } state_t;

    typedef struct packed {
        logic                  valid;
        logic [DEADLINE_W-1:0] deadline;
        logic [ID_W-1:0]       id;
    } cell_data_t;

    typedef struct packed {
        cell_op_t              op;
        logic [DEADLINE_W-1:0] deadline;
        logic [ID_W-1:0]       id;
        logic [ID_W-1:0]       cid;
        logic [DEADLINE_W-1:0] now;
    } cell_cmd_t;

    typedef struct packed {
        logic ins;
        logic rm;
        logic expired;
    } cell_flags_t;

endpackage

// ===== hw/rtl/dtq_cell.sv =====
module dtq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  dtq_pkg::cell_cmd_t   cmd,
    input  dtq_pkg::cell_data_t  left_data,
    input  dtq_pkg::cell_flags_t left_flags,
    input  dtq_pkg::cell_data_t  right_data,
    output dtq_pkg::cell_data_t  data,
    output dtq_pkg::cell_flags_t flags
);

    logic                              valid_reg;
    logic                              valid_next;
    logic [dtq_pkg::DEADLINE_W-1:0]    deadline_reg;
    logic [dtq_pkg::DEADLINE_W-1:0]    deadline_next;
    logic [dtq_pkg::ID_W-1:0]          id_reg;
    logic [dtq_pkg::ID_W-1:0]          id_next;
    logic                              ins_here;
    logic                              match;

    assign ins_here = !valid_reg || (deadline_reg > cmd.deadline);
    assign match    = valid_reg && (id_reg == cmd.cid);

    assign flags.ins     = ins_here;
    assign flags.rm      = left_flags.rm || match;
    assign flags.expired = valid_reg && (deadline_reg <= cmd.now);

    assign data.valid    = valid_reg;
    assign data.deadline = deadline_reg;
    assign data.id       = id_reg;

    always_comb
    begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        id_next       = id_reg;
        case (cmd.op)
            dtq_pkg::CELL_INSERT:
            begin
                if (left_flags.ins)
                begin
                    valid_next    = left_data.valid;
                    deadline_next = left_data.deadline;
                    id_next       = left_data.id;
                end
                else if (ins_here)
                begin
                    valid_next    = 1'b1;
                    deadline_next = cmd.deadline;
                    id_next       = cmd.id;
                end
            end
            dtq_pkg::CELL_REMOVE:
            begin
                if (flags.rm)
                begin
                    valid_next    = right_data.valid;
                    deadline_next = right_data.deadline;
                    id_next       = right_data.id;
                end
            end
            dtq_pkg::CELL_POP:
            begin
                valid_next    = right_data.valid;
                deadline_next = right_data.deadline;
                id_next       = right_data.id;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        id_reg       <= id_next;
    end

endmodule

// ===== hw/rtl/deadline_timer_queue.sv =====
// start and cancel: request and result are both registered; no new request is taken while busy
// tick: request and first result are registered, then one expired timer per cycle;
// a tick stays busy while more expired timers follow, and one expiring none gives a single result
// each operation updates the whole row of sorted cells together
// reset empties the queue and clears the id counter at once; the receiver cannot stall
module deadline_timer_queue #(
    parameter int CAPACITY = dtq_pkg::DEFAULT_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [47:0] deadline,
    input  logic [33:0] cancel_id,
    input  logic [47:0] now_time,
    output logic        done,
    output logic [2:0]  status,
    output logic [33:0] timer_id,
    output logic        last
);

    dtq_pkg::state_t                state_reg;
    dtq_pkg::state_t                state_next;
    dtq_pkg::func_t                 func_reg;
    logic [dtq_pkg::DEADLINE_W-1:0] deadline_reg;
    logic [dtq_pkg::ID_W-1:0]       cid_reg;
    logic [dtq_pkg::DEADLINE_W-1:0] now_reg;
    logic [dtq_pkg::ID_W-1:0]       next_id_reg;
    logic [dtq_pkg::ID_W-1:0]       next_id_next;
    logic [dtq_pkg::ID_W-1:0]       assign_id;
    logic                           done_reg;
    logic                           done_next;
    dtq_pkg::status_t               status_reg;
    dtq_pkg::status_t               status_next;
    logic [dtq_pkg::ID_W-1:0]       timer_id_reg;
    logic [dtq_pkg::ID_W-1:0]       timer_id_next;
    logic                           last_reg;
    logic                           last_next;
    dtq_pkg::cell_op_t              cell_op;
    dtq_pkg::cell_cmd_t             cmd;
    logic                           accept;
    logic                           full;
    logic                           found;
    logic                           head_exp;
    logic                           second_exp;

    dtq_pkg::cell_data_t  cell_data  [CAPACITY];
    dtq_pkg::cell_flags_t cell_flags [CAPACITY];
    dtq_pkg::cell_data_t  left_data  [CAPACITY];
    dtq_pkg::cell_flags_t left_flags [CAPACITY];
    dtq_pkg::cell_data_t  right_data [CAPACITY];

    assign busy   = (state_reg != dtq_pkg::ST_IDLE);
    assign accept = start && !busy;

    assign assign_id = (next_id_reg > dtq_pkg::ID_LIMIT) ? '0 : next_id_reg;

    assign cmd.op       = cell_op;
    assign cmd.deadline = deadline_reg;
    assign cmd.id       = assign_id;
    assign cmd.cid      = cid_reg;
    assign cmd.now      = now_reg;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign left_data[i]  = '0;
                assign left_flags[i] = '0;
            end
            else
            begin : g_body
                assign left_data[i]  = cell_data[i-1];
                assign left_flags[i] = cell_flags[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_data[i] = '0;
            end
            else
            begin : g_inner
                assign right_data[i] = cell_data[i+1];
            end

            dtq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_data  (left_data[i]),
                .left_flags (left_flags[i]),
                .right_data (right_data[i]),
                .data       (cell_data[i]),
                .flags      (cell_flags[i])
            );
        end
    endgenerate

    assign full       = cell_data[CAPACITY-1].valid;
    assign found      = cell_flags[CAPACITY-1].rm;
    assign head_exp   = cell_flags[0].expired;
    assign second_exp = cell_flags[1].expired;

    always_comb
    begin
        state_next    = state_reg;
        cell_op       = dtq_pkg::CELL_HOLD;
        next_id_next  = next_id_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        timer_id_next = timer_id_reg;
        last_next     = last_reg;
        case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dtq_pkg::ST_EXEC;
                end
            end
            dtq_pkg::ST_EXEC:
            begin
                state_next = dtq_pkg::ST_IDLE;
                case (func_reg)
                    dtq_pkg::FUNC_START:
                    begin
                        done_next = 1'b1;
                        last_next = 1'b1;
                        if (full)
                        begin
                            status_next   = dtq_pkg::STATUS_FULL;
                            timer_id_next = '0;
                        end
                        else
                        begin
                            cell_op       = dtq_pkg::CELL_INSERT;
                            status_next   = dtq_pkg::STATUS_STARTED;
                            timer_id_next = assign_id;
                            next_id_next  = assign_id + 1'b1;
                        end
                    end
                    dtq_pkg::FUNC_CANCEL:
                    begin
                        cell_op       = dtq_pkg::CELL_REMOVE;
                        done_next     = 1'b1;
                        last_next     = 1'b1;
                        timer_id_next = cid_reg;
                        status_next   = found ? dtq_pkg::STATUS_CANCELLED
                                              : dtq_pkg::STATUS_NOT_FOUND;
                    end
                    dtq_pkg::FUNC_TICK:
                    begin
                        done_next = 1'b1;
                        if (head_exp)
                        begin
                            cell_op       = dtq_pkg::CELL_POP;
                            status_next   = dtq_pkg::STATUS_EXPIRED;
                            timer_id_next = cell_data[0].id;
                            last_next     = !second_exp;
                            if (second_exp)
                            begin
                                state_next = dtq_pkg::ST_TICK;
                            end
                        end
                        else
                        begin
                            status_next   = dtq_pkg::STATUS_NONE;
                            timer_id_next = '0;
                            last_next     = 1'b1;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end
            dtq_pkg::ST_TICK:
            begin
                cell_op       = dtq_pkg::CELL_POP;
                done_next     = 1'b1;
                status_next   = dtq_pkg::STATUS_EXPIRED;
                timer_id_next = cell_data[0].id;
                last_next     = !second_exp;
                state_next    = second_exp ? dtq_pkg::ST_TICK : dtq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dtq_pkg::ST_IDLE;
            next_id_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            next_id_reg <= next_id_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        timer_id_reg <= timer_id_next;
        last_reg     <= last_next;
        if (accept)
        begin
            func_reg     <= dtq_pkg::func_t'(func);
            deadline_reg <= deadline;
            cid_reg      <= cancel_id;
            now_reg      <= now_time;
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign timer_id = timer_id_reg;
    assign last     = last_reg;

endmodule

// ===== hw/rtl/dtq_checker.sv =====
`include "deadline_timer_queue_defines.svh"

module dtq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [33:0] timer_id,
    input logic        last
);

    // every transfer makes the block busy in the next cycle
    `DTQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // more results pending keeps the block busy
    `DTQ_ASSERT_SAME(a_more_busy, done && !last, busy)
    // only expiries come in runs
    `DTQ_ASSERT_SAME(a_run_expired, done && !last, status == dtq_pkg::STATUS_EXPIRED)
    // a tick with nothing due gives one closing result with id zero
    `DTQ_ASSERT_SAME(a_none_last, done && (status == dtq_pkg::STATUS_NONE),
                     last && (timer_id == '0))

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .timer_id (timer_id),
    .last     (last)
);
